// File: hw/rtl/adc_group_scan_sequencer_core_defines.svh
// Assertion macros for the ADC scan sequencer.
// Each use names clk and rst of the enclosing module.
`ifndef ADC_GROUP_SCAN_SEQUENCER_CORE_DEFINES_SVH
`define ADC_GROUP_SCAN_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define AGSS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AGSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/agss_pkg.sv
package agss_pkg;

  localparam int RAW_W = 12;

  // operation codes on the input side
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_DONE    = 3'd1;
  localparam logic [2:0] OP_ERROR   = 3'd2;
  localparam logic [2:0] OP_REFUSED = 3'd3;
  localparam logic [2:0] OP_PAUSE   = 3'd4;
  localparam logic [2:0] OP_RESUME  = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_STATUS  = 3'd0;
  localparam logic [2:0] KIND_START   = 3'd1;
  localparam logic [2:0] KIND_CANCEL  = 3'd2;
  localparam logic [2:0] KIND_PUBLISH = 3'd3;
  localparam logic [2:0] KIND_STALE   = 3'd4;

  // channels; the phase uses the same codes, plus PH_NONE
  localparam logic [2:0] CH_MID   = 3'd0;
  localparam logic [2:0] CH_HIGH  = 3'd1;
  localparam logic [2:0] CH_LOW   = 3'd2;
  localparam logic [2:0] CH_BATT  = 3'd3;
  localparam logic [2:0] CH_THERM = 3'd4;
  localparam logic [2:0] CH_NONE  = 3'd5;
  localparam logic [2:0] PH_NONE  = 3'd7;

  localparam logic [1:0] GRP_NONE  = 2'd0;
  localparam logic [1:0] GRP_RES   = 2'd1;
  localparam logic [1:0] GRP_BATT  = 2'd2;
  localparam logic [1:0] GRP_THERM = 2'd3;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_RES_PERIOD   = 3'd0;
  localparam logic [2:0] REG_BATT_PERIOD  = 3'd1;
  localparam logic [2:0] REG_THERM_PERIOD = 3'd2;
  localparam logic [2:0] REG_RES_AGE      = 3'd3;
  localparam logic [2:0] REG_BATT_AGE     = 3'd4;
  localparam logic [2:0] REG_THERM_AGE    = 3'd5;
  localparam logic [2:0] REG_SAT_LOW      = 3'd6;
  localparam logic [2:0] REG_SAT_HIGH     = 3'd7;

  localparam logic [15:0]      PERIOD_RST   = 16'd1000;
  localparam logic [15:0]      MAX_AGE_RST  = 16'd3000;
  localparam logic [RAW_W-1:0] SAT_LOW_RST  = '0;
  localparam logic [RAW_W-1:0] SAT_HIGH_RST = '1;

  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       channel;
    logic [1:0]       group;
    logic [RAW_W-1:0] average_raw;
    logic             saturated;
  } res_t;

  function automatic logic [1:0] phase_group(input logic [2:0] p);
    logic [1:0] g;
    case (p)
      CH_MID, CH_HIGH, CH_LOW: g = GRP_RES;
      CH_BATT:                 g = GRP_BATT;
      CH_THERM:                g = GRP_THERM;
      default:                 g = GRP_NONE;
    endcase
    return g;
  endfunction

  function automatic logic [2:0] phase_chan(input logic [2:0] p);
    return (p <= CH_THERM) ? p : CH_NONE;
  endfunction

  function automatic logic is_sat(input logic [RAW_W-1:0] v,
                                  input logic [RAW_W-1:0] lo,
                                  input logic [RAW_W-1:0] hi);
    return (v <= lo) || (v >= hi);
  endfunction

  function automatic res_t make_res(input logic [2:0] kind, input logic [2:0] ch,
                                    input logic [1:0] grp,
                                    input logic [RAW_W-1:0] avg, input logic sat);
    res_t r;
    r.kind        = kind;
    r.channel     = ch;
    r.group       = grp;
    r.average_raw = avg;
    r.saturated   = sat;
    return r;
  endfunction

endpackage

// File: hw/rtl/adc_group_scan_sequencer_core.sv
// An accepted input word passes the input register and then the result bundle, which drives m_*.
// Throughput: one input word per cycle while the bundle can take it; an event that causes k results
// (1 to 4) holds the bundle until all k words have left, one word per cycle while m_tready is high.
// Reset (rst, synchronous, active high): idle, no group, all groups due at once,
// fault clear, registers at their defaults, both stream sides empty.
`include "adc_group_scan_sequencer_core_defines.svh"

module adc_group_scan_sequencer_core #(
  parameter int AVERAGE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // now_ms[31:0], sample_raw[43:32], zero[47:44]
  input  logic [2:0]  s_tuser,   // operation[2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // channel[2:0], group[4:3], average_raw[16:5],
                                 // saturated[17], fault[18], busy_res[19], zero[23:20]
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import agss_pkg::*;

  // accumulator wide enough for AVERAGE_COUNT full-scale samples
  localparam int CNT_W   = $clog2(AVERAGE_COUNT);
  localparam int ACC_W   = RAW_W + CNT_W;
  // exact floor division by a constant: x * ceil(2^(N+l)/d) >> (N+l)
  localparam int DIV_SH  = ACC_W + CNT_W;
  localparam int RECIP_W = ACC_W + 1;
  localparam int PROD_W  = ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** DIV_SH + AVERAGE_COUNT - 1) / AVERAGE_COUNT);
  localparam logic [ACC_W-1:0] HALF = ACC_W'(AVERAGE_COUNT / 2);
  localparam logic [CNT_W:0]   AVG_N = (CNT_W + 1)'(AVERAGE_COUNT);

  typedef enum logic [1:0] {MODE_IDLE, MODE_START, MODE_POLL, MODE_PAUSED} mode_t;

  // ---------------- configuration registers ----------------
  logic [15:0]      period [3];
  logic [15:0]      max_age [3];
  logic [RAW_W-1:0] sat_low, sat_high;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      REG_RES_PERIOD:   prdata = {16'b0, period[0]};
      REG_BATT_PERIOD:  prdata = {16'b0, period[1]};
      REG_THERM_PERIOD: prdata = {16'b0, period[2]};
      REG_RES_AGE:      prdata = {16'b0, max_age[0]};
      REG_BATT_AGE:     prdata = {16'b0, max_age[1]};
      REG_THERM_AGE:    prdata = {16'b0, max_age[2]};
      REG_SAT_LOW:      prdata = {20'b0, sat_low};
      REG_SAT_HIGH:     prdata = {20'b0, sat_high};
      default:          prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic             in_valid;
  logic [2:0]       in_op;
  logic [31:0]      in_now;
  logic [RAW_W-1:0] in_raw;

  // ---------------- sequencer state ----------------
  mode_t            mode, mode_next;
  logic [2:0]       phase, phase_next;
  logic [CNT_W-1:0] sample_count, sample_count_next;
  logic [ACC_W-1:0] acc [3];
  logic [ACC_W-1:0] acc_next [3];
  logic [ACC_W-1:0] acc_add [3];
  logic             gsat, gsat_next;
  logic             fault, fault_next;
  logic [31:0]      group_start, group_start_next;
  logic [31:0]      next_due [3];
  logic [31:0]      next_due_next [3];
  logic [31:0]      pub_ms [3];
  logic [31:0]      pub_ms_next [3];
  logic [2:0]       pub_valid, pub_valid_next;

  // ---------------- result bundle (output side) ----------------
  res_t             slot [4];
  res_t             slot_next [4];
  logic [2:0]       n_res;
  logic [2:0]       b_count;
  logic [1:0]       b_idx;
  logic             b_valid, b_fault, b_busy;
  res_t             cur;
  logic             at_last, drain_done, advance, fire;

  assign cur        = slot[b_idx];
  assign at_last    = ({1'b0, b_idx} + 3'd1) == b_count;
  assign drain_done = b_valid && m_tready && at_last;
  // bundle can take a new event when empty or when its final word leaves now
  assign advance    = !b_valid || drain_done;
  assign fire       = in_valid && advance;
  assign s_tready   = !in_valid || advance;

  assign m_tvalid = b_valid;
  assign m_tlast  = at_last;
  assign m_tuser  = cur.kind;
  assign m_tdata  = {4'b0, b_busy, b_fault, cur.saturated, cur.average_raw,
                     cur.group, cur.channel};

  // rounded mean, clamped to full scale
  function automatic logic [RAW_W-1:0] mean_of(input logic [ACC_W-1:0] sum);
    logic [ACC_W-1:0]  x;
    logic [PROD_W-1:0] prod;
    logic [RAW_W:0]    q;
    x    = sum + HALF;
    prod = {{RECIP_W{1'b0}}, x} * {{ACC_W{1'b0}}, RECIP};
    q    = prod[PROD_W-1:DIV_SH];
    return q[RAW_W] ? '1 : q[RAW_W-1:0];
  endfunction

  // ---------------- per-event datapath ----------------
  logic [1:0]       samp_slot;
  logic [RAW_W-1:0] mean [3];
  logic [2:0]       stale, due;
  logic [CNT_W:0]   cnt_inc;

  assign samp_slot = (phase <= CH_LOW) ? phase[1:0] : 2'd0;
  assign cnt_inc   = {1'b0, sample_count} + (CNT_W + 1)'(1);

  for (genvar g = 0; g < 3; g++) begin : g_grp
    logic [31:0] age, lag;
    assign acc_add[g] = acc[g] + ((samp_slot == 2'(g)) ? ACC_W'(in_raw) : '0);
    assign mean[g]    = mean_of(acc_add[g]);
    assign age        = in_now - pub_ms[g];
    assign stale[g]   = pub_valid[g] && (age > {16'b0, max_age[g]});
    // wrap-safe: due while now - deadline is in the lower half range
    assign lag        = in_now - next_due[g];
    assign due[g]     = !lag[31];
  end

  logic       do_drop;
  mode_t      drop_mode;
  logic [1:0] fin_grp, fin_idx;

  assign fin_grp = phase_group(phase);
  assign fin_idx = fin_grp - 2'd1;

  always_comb begin
    mode_next         = mode;
    phase_next        = phase;
    sample_count_next = sample_count;
    acc_next          = acc;
    gsat_next         = gsat;
    fault_next        = fault;
    group_start_next  = group_start;
    next_due_next     = next_due;
    pub_ms_next       = pub_ms;
    pub_valid_next    = pub_valid;
    slot_next         = slot;
    n_res             = 3'd0;
    do_drop           = 1'b0;
    drop_mode         = MODE_IDLE;

    case (in_op)
      OP_TICK: begin
        if (mode != MODE_PAUSED) begin
          for (int i = 0; i < 3; i++) begin
            if (stale[i]) begin
              pub_valid_next[i] = 1'b0;
              slot_next[n_res[1:0]] = make_res(KIND_STALE, CH_NONE, 2'(i + 1), '0, gsat);
              n_res = n_res + 3'd1;
            end
          end
          if (mode == MODE_IDLE && due != 3'b000) begin
            // residual first, then battery, then thermistor
            phase_next = due[0] ? CH_MID : (due[1] ? CH_BATT : CH_THERM);
            for (int i = 0; i < 3; i++) acc_next[i] = '0;
            sample_count_next = '0;
            gsat_next         = 1'b0;
            group_start_next  = in_now;
            mode_next         = MODE_START;
          end
          if (mode_next == MODE_START) begin
            slot_next[n_res[1:0]] = make_res(KIND_START, phase_chan(phase_next),
                                             phase_group(phase_next), '0, gsat_next);
            n_res     = n_res + 3'd1;
            mode_next = MODE_POLL;
          end
        end
      end
      OP_DONE: begin
        if (mode == MODE_POLL) begin
          acc_next = acc_add;
          if (phase == CH_HIGH || phase == CH_LOW)
            gsat_next = gsat || is_sat(in_raw, sat_low, sat_high);
          if (cnt_inc < AVG_N) begin
            sample_count_next = cnt_inc[CNT_W-1:0];
            mode_next         = MODE_START;
          end else if (phase < CH_LOW) begin
            sample_count_next = '0;
            phase_next        = phase + 3'd1;
            mode_next         = MODE_START;
          end else begin
            // last sample of the group: publish and reschedule
            case (fin_grp)
              GRP_RES: begin
                slot_next[0] = make_res(KIND_PUBLISH, CH_MID, GRP_RES, mean[0], gsat_next);
                slot_next[1] = make_res(KIND_PUBLISH, CH_HIGH, GRP_RES, mean[1], gsat_next);
                slot_next[2] = make_res(KIND_PUBLISH, CH_LOW, GRP_RES, mean[2], gsat_next);
                n_res = 3'd3;
              end
              GRP_BATT: begin
                slot_next[0] = make_res(KIND_PUBLISH, CH_BATT, GRP_BATT, mean[0], gsat_next);
                n_res = 3'd1;
              end
              GRP_THERM: begin
                slot_next[0] = make_res(KIND_PUBLISH, CH_THERM, GRP_THERM, mean[0],
                                        is_sat(mean[0], sat_low, sat_high));
                n_res = 3'd1;
              end
              default: ;
            endcase
            if (fin_grp != GRP_NONE) begin
              pub_ms_next[fin_idx]    = group_start;
              pub_valid_next[fin_idx] = 1'b1;
              next_due_next[fin_idx]  = group_start + {16'b0, period[fin_idx]};
            end
            do_drop = 1'b1;
          end
        end
      end
      OP_ERROR: begin
        if (mode == MODE_POLL) begin
          slot_next[0] = make_res(KIND_CANCEL, phase_chan(phase), phase_group(phase),
                                  '0, gsat);
          n_res      = 3'd1;
          fault_next = 1'b1;
          do_drop    = 1'b1;
        end
      end
      OP_REFUSED: begin
        if (mode == MODE_POLL) begin
          fault_next = 1'b1;
          do_drop    = 1'b1;
        end
      end
      OP_PAUSE: begin
        if (mode != MODE_PAUSED) begin
          if (mode == MODE_POLL) begin
            slot_next[0] = make_res(KIND_CANCEL, phase_chan(phase), phase_group(phase),
                                    '0, gsat);
            n_res = 3'd1;
          end
          do_drop   = 1'b1;
          drop_mode = MODE_PAUSED;
        end
      end
      OP_RESUME: begin
        if (mode == MODE_POLL) begin
          slot_next[0] = make_res(KIND_CANCEL, phase_chan(phase), phase_group(phase),
                                  '0, gsat);
          n_res = 3'd1;
        end
        do_drop = 1'b1;
        for (int i = 0; i < 3; i++) next_due_next[i] = in_now;
      end
      default: ;
    endcase

    if (do_drop) begin
      for (int i = 0; i < 3; i++) acc_next[i] = '0;
      sample_count_next = '0;
      gsat_next         = 1'b0;
      phase_next        = PH_NONE;
      mode_next         = drop_mode;
    end

    // nothing else to say: one status word
    if (n_res == 3'd0) begin
      if (mode_next == MODE_START || mode_next == MODE_POLL)
        slot_next[0] = make_res(KIND_STATUS, phase_chan(phase_next),
                                phase_group(phase_next), '0, gsat_next);
      else
        slot_next[0] = make_res(KIND_STATUS, CH_NONE, GRP_NONE, '0, gsat_next);
      n_res = 3'd1;
    end
  end

  // ---------------- state, registers and outputs ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        period[i]    <= PERIOD_RST;
        max_age[i]   <= MAX_AGE_RST;
        next_due[i]  <= '0;
        pub_ms[i]    <= '0;
        acc[i]       <= '0;
      end
      sat_low      <= SAT_LOW_RST;
      sat_high     <= SAT_HIGH_RST;
      in_valid     <= 1'b0;
      mode         <= MODE_IDLE;
      phase        <= PH_NONE;
      sample_count <= '0;
      gsat         <= 1'b0;
      fault        <= 1'b0;
      group_start  <= '0;
      pub_valid    <= '0;
      b_valid      <= 1'b0;
      b_idx        <= '0;
      b_count      <= 3'd1;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_RES_PERIOD:   period[0]  <= pwdata[15:0];
          REG_BATT_PERIOD:  period[1]  <= pwdata[15:0];
          REG_THERM_PERIOD: period[2]  <= pwdata[15:0];
          REG_RES_AGE:      max_age[0] <= pwdata[15:0];
          REG_BATT_AGE:     max_age[1] <= pwdata[15:0];
          REG_THERM_AGE:    max_age[2] <= pwdata[15:0];
          REG_SAT_LOW:      sat_low    <= pwdata[RAW_W-1:0];
          REG_SAT_HIGH:     sat_high   <= pwdata[RAW_W-1:0];
          default: ;
        endcase
      end
      if (s_tready) in_valid <= s_tvalid;
      if (fire) begin
        mode         <= mode_next;
        phase        <= phase_next;
        sample_count <= sample_count_next;
        acc          <= acc_next;
        gsat         <= gsat_next;
        fault        <= fault_next;
        group_start  <= group_start_next;
        next_due     <= next_due_next;
        pub_ms       <= pub_ms_next;
        pub_valid    <= pub_valid_next;
        b_valid      <= 1'b1;
        b_idx        <= '0;
        b_count      <= n_res;
      end else if (drain_done) begin
        b_valid <= 1'b0;
      end else if (b_valid && m_tready) begin
        b_idx <= b_idx + 2'd1;
      end
    end
    // payload, no reset needed
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_now <= s_tdata[31:0];
      in_raw <= s_tdata[43:32];
    end
    if (fire) begin
      slot    <= slot_next;
      b_fault <= fault_next;
      b_busy  <= (mode_next == MODE_START) || (mode_next == MODE_POLL);
    end
  end

  // ---------------- assertions ----------------
  `AGSS_ASSERT_NOW(a_bundle_count, b_valid, (b_count != 3'd0) && (b_count <= 3'd4),
                   "result bundle holds no word or too many")
  `AGSS_ASSERT_NOW(a_active_phase, (mode == MODE_START) || (mode == MODE_POLL),
                   phase <= CH_THERM, "active group without a phase")
  `AGSS_ASSERT_NOW(a_quiet_clear, (mode == MODE_IDLE) || (mode == MODE_PAUSED),
                   (phase == PH_NONE) && (sample_count == '0) && !gsat,
                   "group state left over while no group runs")
  `AGSS_ASSERT_NEXT(a_fire_loads, fire, b_valid && (b_idx == 2'd0),
                    "event not loaded into the result bundle")
  `AGSS_ASSERT_NEXT(a_fault_sticky, fault, fault, "fault flag cleared outside reset")

endmodule
